[src/fprc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fprc_pkg
// Shared types and constants of the framed packet receive checker.
// ----------------------------------------------------------------------------
package fprc_pkg;

    localparam int POS_W  = 17;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 64;

    localparam logic [POS_W-1:0] POS_MAX       = '1;
    localparam logic [7:0]       HEAD_HI       = 8'h4A;
    localparam logic [7:0]       HEAD_LO       = 8'h54;
    localparam logic [POS_W:0]   MIN_FRAME     = 18'd21;
    localparam logic [POS_W-1:0] PAYLOAD_START = 17'd19;

    // Fixed byte positions inside the frame
    localparam logic [POS_W-1:0] POS_HEAD_HI = 17'd0;
    localparam logic [POS_W-1:0] POS_HEAD_LO = 17'd1;
    localparam logic [POS_W-1:0] POS_ID_FIRST = 17'd2;
    localparam logic [POS_W-1:0] POS_ID_LAST = 17'd9;
    localparam logic [POS_W-1:0] POS_SERIAL_HI = 17'd10;
    localparam logic [POS_W-1:0] POS_SERIAL_LO = 17'd11;
    localparam logic [POS_W-1:0] POS_ITEM = 17'd13;
    localparam logic [POS_W-1:0] POS_FUNC_HI = 17'd15;
    localparam logic [POS_W-1:0] POS_FUNC_LO = 17'd16;
    localparam logic [POS_W-1:0] POS_LEN_HI = 17'd17;
    localparam logic [POS_W-1:0] POS_LEN_LO = 17'd18;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ID   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ITEM_NUMBER = 1'd1;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_SHORT      = 3'd1,
        ST_BAD_HEADER = 3'd2,
        ST_BAD_SUM    = 3'd3,
        ST_OTHER_DEV  = 3'd4,
        ST_OTHER_ITEM = 3'd5
    } t_status;

    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        t_status     status;
        logic [15:0] serial_number;
        logic [15:0] function_code;
        logic [15:0] payload_length;
    } t_result;

    typedef struct packed {
        logic    has;
        t_result res;
    } t_core_out;

endpackage : fprc_pkg
`default_nettype wire

[src/fprc_byte_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fprc_byte_if
// Request channel carrying received frame bytes.
// ----------------------------------------------------------------------------
interface fprc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last;

    modport source (output valid, output data_byte, output last, input ready);
    modport sink (input valid, input data_byte, input last, output ready);
endinterface : fprc_byte_if
`default_nettype wire

[src/fprc_result_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fprc_result_if
// Result channel carrying payload bytes and end-of-frame verdicts.
// ----------------------------------------------------------------------------
interface fprc_result_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  payload_byte;
    logic [2:0]  status;
    logic [15:0] serial_number;
    logic [15:0] function_code;
    logic [15:0] payload_length;

    modport source (output valid, output kind, output payload_byte, output status,
                    output serial_number, output function_code,
                    output payload_length, input ready);
    modport sink (input valid, input kind, input payload_byte, input status,
                  input serial_number, input function_code,
                  input payload_length, output ready);
endinterface : fprc_result_if
`default_nettype wire

[src/fprc_cfg_regs.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fprc_cfg_regs
// Configuration registers: own device id and expected item number.
// ----------------------------------------------------------------------------
module fprc_cfg_regs (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [fprc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [fprc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output logic      [63:0]                      o_device_id,
    output logic      [7:0]                       o_item_number
);
    import fprc_pkg::*;

    logic [63:0] r_device_id;
    logic [7:0]  r_item_number;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_id   <= '0;
            r_item_number <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DEVICE_ID: begin
                    r_device_id <= i_cfg_data;
                end
                CFG_ITEM_NUMBER: begin
                    r_item_number <= i_cfg_data[7:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_device_id   = r_device_id;
    assign o_item_number = r_item_number;

endmodule : fprc_cfg_regs
`default_nettype wire

[src/fprc_frame_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fprc_frame_core
// Per-byte frame parser: position tracking, field capture, running sum and
// the end-of-frame verdict, all settled in one pass per byte.
// ----------------------------------------------------------------------------
module fprc_frame_core (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_step,
    input  wire logic [7:0]             i_byte,
    input  wire logic                   i_last,
    input  wire logic [63:0]            i_device_id,
    input  wire logic [7:0]             i_item_number,
    output fprc_pkg::t_core_out         o_out
);
    import fprc_pkg::*;

    logic [POS_W-1:0] r_pos, n_pos;
    logic [15:0]      r_sum, n_sum;
    logic             r_head_ok, n_head_ok;
    logic             r_id_ok, n_id_ok;
    logic             r_item_ok, n_item_ok;
    logic [15:0]      r_serial, n_serial;
    logic [15:0]      r_func, n_func;
    logic [15:0]      r_len, n_len;
    logic [15:0]      r_rx_sum, n_rx_sum;

    logic             w_ge_start;
    logic [POS_W-1:0] w_off;
    logic [POS_W-1:0] w_tail;
    logic             w_in_sum;
    logic             w_is_payload;
    logic [2:0]       w_id_idx;
    logic [7:0]       w_id_byte;
    logic [POS_W:0]   w_total;
    logic [POS_W:0]   w_need;
    t_status          w_status;

    always_comb begin
        w_ge_start   = (r_pos >= PAYLOAD_START);
        w_off        = r_pos - PAYLOAD_START;
        w_tail       = w_off - {1'b0, r_len};
        w_in_sum     = !w_ge_start || (w_off < {1'b0, r_len});
        w_is_payload = w_ge_start && w_in_sum;
        // Byte 2 carries the most significant id byte
        w_id_idx     = 3'(4'd9 - r_pos[3:0]);
        w_id_byte    = i_device_id[{w_id_idx, 3'b000} +: 8];

        n_head_ok = r_head_ok;
        n_id_ok   = r_id_ok;
        n_item_ok = r_item_ok;
        n_serial  = r_serial;
        n_func    = r_func;
        n_len     = r_len;
        n_rx_sum  = r_rx_sum;

        if (r_pos == POS_HEAD_HI) begin
            n_head_ok = r_head_ok && (i_byte == HEAD_HI);
        end else if (r_pos == POS_HEAD_LO) begin
            n_head_ok = r_head_ok && (i_byte == HEAD_LO);
        end else if (r_pos >= POS_ID_FIRST && r_pos <= POS_ID_LAST) begin
            n_id_ok = r_id_ok && (w_id_byte == i_byte);
        end else if (r_pos == POS_SERIAL_HI || r_pos == POS_SERIAL_LO) begin
            n_serial = {r_serial[7:0], i_byte};
        end else if (r_pos == POS_ITEM) begin
            n_item_ok = (i_byte == i_item_number);
        end else if (r_pos == POS_FUNC_HI || r_pos == POS_FUNC_LO) begin
            n_func = {r_func[7:0], i_byte};
        end else if (r_pos == POS_LEN_HI || r_pos == POS_LEN_LO) begin
            n_len = {r_len[7:0], i_byte};
        end else if (!w_in_sum && w_tail < 17'd2) begin
            n_rx_sum = {r_rx_sum[7:0], i_byte};
        end

        n_sum = w_in_sum ? (r_sum + {8'd0, i_byte}) : r_sum;
        n_pos = (r_pos != POS_MAX) ? (r_pos + 1'b1) : r_pos;

        // Verdict uses the state as it stands after this byte
        w_total = {1'b0, r_pos} + 1'b1;
        w_need  = MIN_FRAME + {2'b00, n_len};
        if (w_total < MIN_FRAME || w_total < w_need) begin
            w_status = ST_SHORT;
        end else if (!n_head_ok) begin
            w_status = ST_BAD_HEADER;
        end else if (n_rx_sum != n_sum) begin
            w_status = ST_BAD_SUM;
        end else if (!n_id_ok) begin
            w_status = ST_OTHER_DEV;
        end else if (!n_item_ok) begin
            w_status = ST_OTHER_ITEM;
        end else begin
            w_status = ST_OK;
        end

        o_out = '0;
        o_out.res.status = ST_OK;
        if (i_last) begin
            o_out.has                = 1'b1;
            o_out.res.kind           = KIND_VERDICT;
            o_out.res.status         = w_status;
            o_out.res.serial_number  = n_serial;
            o_out.res.function_code  = n_func;
            o_out.res.payload_length = n_len;
        end else if (w_is_payload) begin
            o_out.has              = 1'b1;
            o_out.res.kind         = KIND_PAYLOAD;
            o_out.res.payload_byte = i_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last)) begin
            // Drop frame state back to its idle values
            r_pos     <= '0;
            r_sum     <= '0;
            r_head_ok <= 1'b1;
            r_id_ok   <= 1'b1;
            r_item_ok <= 1'b0;
            r_serial  <= '0;
            r_func    <= '0;
            r_len     <= '0;
            r_rx_sum  <= '0;
        end else if (i_step) begin
            r_pos     <= n_pos;
            r_sum     <= n_sum;
            r_head_ok <= n_head_ok;
            r_id_ok   <= n_id_ok;
            r_item_ok <= n_item_ok;
            r_serial  <= n_serial;
            r_func    <= n_func;
            r_len     <= n_len;
            r_rx_sum  <= n_rx_sum;
        end
    end

`ifndef ASSERT_OFF
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_last |=> r_pos == '0 && r_sum == '0 && r_head_ok && r_id_ok)
        else $error("frame state not cleared after last byte");

    a_pos_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && !i_last && r_pos != POS_MAX |=> r_pos == $past(r_pos) + 1'b1)
        else $error("byte position did not advance");

    a_hold_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> $stable(r_pos) && $stable(r_sum) && $stable(r_len))
        else $error("frame state moved without a byte");
`endif

endmodule : fprc_frame_core
`default_nettype wire

[src/framed_packet_receive_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// framed_packet_receive_checker
// Checks received frames byte by byte, forwards payload and gives a verdict.
// ----------------------------------------------------------------------------
// Takes one frame byte per clock cycle when the result side keeps up: a byte
// is held in the input register, parsed in a single pass by the frame core
// (field compare, 16-bit running sum, verdict priority), and its result, if
// any, lands in the output register. Payload bytes come out as they arrive;
// the last byte of a frame yields the verdict with status, serial, function
// code and length instead. Bytes that give no result still pass through the
// input register one per cycle while the result side keeps up. A new byte is
// taken while the previous result waits; a stall on the result side holds the
// input register after that. Configuration writes take effect the next cycle
// and must be done between frames.
// ----------------------------------------------------------------------------
module framed_packet_receive_checker (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    fprc_byte_if.sink                             i_in,
    fprc_result_if.source                         o_out,
    input  wire logic                             i_cfg_we,
    input  wire logic [fprc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [fprc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import fprc_pkg::*;

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;
    logic        r_out_valid;
    t_result     r_out;

    logic        w_advance;
    logic [63:0] w_device_id;
    logic [7:0]  w_item_number;
    t_core_out   w_core;

    fprc_cfg_regs u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_device_id   (w_device_id),
        .o_item_number (w_item_number)
    );

    fprc_frame_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (w_advance),
        .i_byte        (r_in_byte),
        .i_last        (r_in_last),
        .i_device_id   (w_device_id),
        .i_item_number (w_item_number),
        .o_out         (w_core)
    );

    // Advance the held byte once the result register can take its outcome
    assign w_advance = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (w_advance) begin
                r_out_valid <= w_core.has;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_byte <= i_in.data_byte;
            r_in_last <= i_in.last;
        end
        if (w_advance) begin
            r_out <= w_core.res;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.kind           = r_out.kind;
    assign o_out.payload_byte   = r_out.payload_byte;
    assign o_out.status         = r_out.status;
    assign o_out.serial_number  = r_out.serial_number;
    assign o_out.function_code  = r_out.function_code;
    assign o_out.payload_length = r_out.payload_length;

`ifndef ASSERT_OFF
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_advance |=> r_in_valid && $stable(r_in_byte) && $stable(r_in_last))
        else $error("held request lost while result side stalled");

    a_out_from_core: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance && w_core.has |=> r_out_valid)
        else $error("core result not captured");

    a_verdict_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance && r_in_last |=> r_out_valid && r_out.kind == KIND_VERDICT)
        else $error("last byte did not yield a verdict");
`endif

endmodule : framed_packet_receive_checker
`default_nettype wire

[sim/fprc_frame_model_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fprc_frame_model_pkg
// Expected-output model and scoreboard for the framed packet receive checker.
// ----------------------------------------------------------------------------
// Follows each accepted frame byte the way the block parses it: header and
// device id compares, serial / function / length capture, 16-bit running sum,
// received checksum and the verdict priority at the last byte. Payload bytes
// and verdicts queue up in order and are compared against the result channel.
// ----------------------------------------------------------------------------
package fprc_frame_model_pkg;
    import fprc_pkg::*;

    class frame_check_model;
        logic [CFG_DATA_W-1:0] own_id;
        logic [7:0]            own_item;
        logic [POS_W-1:0]      pos;
        logic [15:0]           sum_acc;
        logic [15:0]           sum_rx;
        logic [15:0]           serial_st;
        logic [15:0]           func_st;
        logic [15:0]           len_st;
        bit                    head_ok;
        bit                    id_ok;
        bit                    item_ok;
        t_result               due_q[$];
        int unsigned           mismatch_count;
        int unsigned           byte_count;
        int unsigned           payload_count;
        int unsigned           verdict_count[6];

        function new();
            own_id = '0;
            own_item = '0;
            mismatch_count = 0;
            byte_count = 0;
            payload_count = 0;
            foreach (verdict_count[i]) verdict_count[i] = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            pos = '0;
            sum_acc = '0;
            sum_rx = '0;
            serial_st = '0;
            func_st = '0;
            len_st = '0;
            head_ok = 1'b1;
            id_ok = 1'b1;
            item_ok = 1'b0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_DEVICE_ID:   own_id = val;
                CFG_ITEM_NUMBER: own_item = val[7:0];
                default: ;
            endcase
        endfunction

        function int unsigned outstanding();
            return due_q.size();
        endfunction

        // Advance the frame state by one accepted request and queue its output.
        function void predict_from_byte(logic [7:0] b, logic last);
            int unsigned p;
            int unsigned sh;
            int unsigned total;
            bit          in_body;
            bit          is_payload;
            t_result     r;
            p = pos;
            in_body = (p < PAYLOAD_START) || (p - PAYLOAD_START < len_st);
            is_payload = (p >= PAYLOAD_START) && in_body;
            byte_count++;
            if (pos == POS_HEAD_HI) begin
                head_ok = head_ok && (b == HEAD_HI);
            end else if (pos == POS_HEAD_LO) begin
                head_ok = head_ok && (b == HEAD_LO);
            end else if (pos >= POS_ID_FIRST && pos <= POS_ID_LAST) begin
                sh = (POS_ID_LAST - p) * 8;
                id_ok = id_ok && (own_id[sh +: 8] == b);
            end else if (pos == POS_SERIAL_HI || pos == POS_SERIAL_LO) begin
                serial_st = {serial_st[7:0], b};
            end else if (pos == POS_ITEM) begin
                item_ok = (b == own_item);
            end else if (pos == POS_FUNC_HI || pos == POS_FUNC_LO) begin
                func_st = {func_st[7:0], b};
            end else if (pos == POS_LEN_HI || pos == POS_LEN_LO) begin
                len_st = {len_st[7:0], b};
            end else if (!in_body && (p - PAYLOAD_START - len_st < 2)) begin
                sum_rx = {sum_rx[7:0], b};
            end
            if (in_body) sum_acc = sum_acc + b;
            // hold the position at its top value on very long frames
            if (pos != POS_MAX) pos = pos + 1'b1;

            if (last) begin
                total = p + 1;
                r.kind = KIND_VERDICT;
                r.payload_byte = 8'h00;
                if (total < MIN_FRAME || total < MIN_FRAME + len_st) begin
                    r.status = ST_SHORT;
                end else if (!head_ok) begin
                    r.status = ST_BAD_HEADER;
                end else if (sum_rx != sum_acc) begin
                    r.status = ST_BAD_SUM;
                end else if (!id_ok) begin
                    r.status = ST_OTHER_DEV;
                end else if (!item_ok) begin
                    r.status = ST_OTHER_ITEM;
                end else begin
                    r.status = ST_OK;
                end
                r.serial_number = serial_st;
                r.function_code = func_st;
                r.payload_length = len_st;
                verdict_count[r.status]++;
                due_q.push_back(r);
                clear_frame();
            end else if (is_payload) begin
                r.kind = KIND_PAYLOAD;
                r.payload_byte = b;
                r.status = ST_OK;
                r.serial_number = '0;
                r.function_code = '0;
                r.payload_length = '0;
                payload_count++;
                due_q.push_back(r);
            end
        endfunction

        function void check_output(t_result got);
            t_result want;
            bit      bad;
            if (due_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("[%0t] unexpected result: kind=%0d byte=%02h status=%0d",
                             $realtime, got.kind, got.payload_byte, got.status);
                return;
            end
            want = due_q.pop_front();
            bad = (got.kind !== want.kind)
                || (got.payload_byte !== want.payload_byte)
                || (got.status !== want.status)
                || (got.serial_number !== want.serial_number)
                || (got.function_code !== want.function_code)
                || (got.payload_length !== want.payload_length);
            if (bad) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("[%0t] mismatch exp: kind=%0d byte=%02h st=%0d ser=%04h fn=%04h len=%04h",
                             $realtime, want.kind, want.payload_byte, want.status,
                             want.serial_number, want.function_code, want.payload_length);
                    $display("             got: kind=%0d byte=%02h st=%0d ser=%04h fn=%04h len=%04h",
                             got.kind, got.payload_byte, got.status,
                             got.serial_number, got.function_code, got.payload_length);
                end
            end
        endfunction
    endclass

endpackage : fprc_frame_model_pkg

[sim/framed_packet_receive_checker_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framed_packet_receive_checker_tb
// Self-checking bench for the framed packet receive checker.
// ----------------------------------------------------------------------------
// Sends directed frames (each verdict, priority between faults, short frames
// cut at several points, trailing bytes, a huge declared length cut short), then
// random well-formed, faulty, truncated and noise frames under several device
// id / item settings. Both channels idle at random; the result side also
// holds off long enough to stall input.
// ----------------------------------------------------------------------------
module framed_packet_receive_checker_tb;
    import fprc_pkg::*;
    import fprc_frame_model_pkg::*;

    localparam int unsigned     RANDOM_BYTES  = 800;
    localparam int unsigned     GAP_PCT       = 30;
    localparam int unsigned     SETTLE_CYCLES = 4;
    localparam int unsigned     HOLD_CYCLES   = 300;
    localparam longint unsigned WATCHDOG_NS   = 64'd16_000_000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    fprc_byte_if   byte_ch ();
    fprc_result_if result_ch ();

    framed_packet_receive_checker dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (byte_ch),
        .o_out       (result_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    frame_check_model      frame_pred;
    bit                    gaps_on;
    int unsigned           hold_left;
    int unsigned           random_sent;
    logic [7:0]            frame_bytes[$];
    logic [CFG_DATA_W-1:0] cur_id;
    logic [7:0]            cur_item;

    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Sample both handshakes on the edge, before any of its updates land.
    always @(posedge i_clk) begin : watch_ports
        t_result got;
        if (i_rst_n) begin
            if (byte_ch.valid && byte_ch.ready)
                frame_pred.predict_from_byte(byte_ch.data_byte, byte_ch.last);
            if (result_ch.valid && result_ch.ready) begin
                got.kind = result_ch.kind;
                got.payload_byte = result_ch.payload_byte;
                got.status = t_status'(result_ch.status);
                got.serial_number = result_ch.serial_number;
                got.function_code = result_ch.function_code;
                got.payload_length = result_ch.payload_length;
                frame_pred.check_output(got);
            end
        end
    end

    initial begin : result_sink
        result_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end else if (gaps_on) begin
                result_ch.ready <= ($urandom_range(0, 99) >= GAP_PCT);
            end else begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        #(WATCHDOG_NS);
        $display("watchdog expired, %0d results still awaited", frame_pred.outstanding());
        $display("end of test: mismatches");
        $finish;
    end

    // Offer one request; valid stays high so back-to-back requests need no toggle.
    task automatic send_byte(input logic [7:0] b, input logic last);
        if (gaps_on) begin
            while ($urandom_range(0, 99) < GAP_PCT) begin
                byte_ch.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        byte_ch.valid <= 1'b1;
        byte_ch.data_byte <= b;
        byte_ch.last <= last;
        do @(posedge i_clk); while (!byte_ch.ready);
    endtask

    task automatic send_frame();
        foreach (frame_bytes[i])
            send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    endtask

    // Drop valid and wait for every awaited result plus the pipeline depth.
    task automatic settle();
        byte_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (frame_pred.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_settings(input logic [CFG_DATA_W-1:0] id, input logic [7:0] item);
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_DEVICE_ID;
        i_cfg_data <= id;
        @(posedge i_clk);
        // upper bits of the write data are junk for the item register
        i_cfg_index <= CFG_ITEM_NUMBER;
        i_cfg_data <= {$urandom, 24'($urandom_range(0, 16777215)), item};
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        frame_pred.set_register(CFG_DEVICE_ID, id);
        frame_pred.set_register(CFG_ITEM_NUMBER, {{(CFG_DATA_W-8){1'b0}}, item});
        cur_id = id;
        cur_item = item;
    endtask

    function automatic logic [7:0] fill_or_random(int fill);
        return (fill < 0) ? 8'($urandom_range(0, 255)) : fill[7:0];
    endfunction

    // Build a frame for the current settings; keep >= 0 truncates it to that many bytes.
    task automatic compose_frame(input int unsigned plen, input bit bad_head,
                                 input bit bad_sum, input bit bad_id, input bit bad_item,
                                 input int unsigned tail, input int keep, input int fill);
        logic [15:0] sum;
        frame_bytes.delete();
        frame_bytes.push_back(HEAD_HI);
        frame_bytes.push_back(HEAD_LO);
        for (int i = 0; i < 8; i++) frame_bytes.push_back(cur_id[(7 - i) * 8 +: 8]);
        repeat (3) frame_bytes.push_back(fill_or_random(fill));
        frame_bytes.push_back(cur_item);
        repeat (3) frame_bytes.push_back(fill_or_random(fill));
        frame_bytes.push_back(plen[15:8]);
        frame_bytes.push_back(plen[7:0]);
        for (int unsigned i = 0; i < plen && (keep < 0 || frame_bytes.size() < keep); i++)
            frame_bytes.push_back(fill_or_random(fill));
        if (bad_head)
            frame_bytes[$urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
        if (bad_id)
            frame_bytes[$urandom_range(POS_ID_FIRST, POS_ID_LAST)] ^= 8'($urandom_range(1, 255));
        if (bad_item)
            frame_bytes[POS_ITEM] ^= 8'($urandom_range(1, 255));
        sum = '0;
        foreach (frame_bytes[i]) sum = sum + frame_bytes[i];
        if (bad_sum) sum ^= 16'($urandom_range(1, 65535));
        frame_bytes.push_back(sum[15:8]);
        frame_bytes.push_back(sum[7:0]);
        repeat (tail) frame_bytes.push_back(8'($urandom_range(0, 255)));
        if (keep >= 0)
            while (frame_bytes.size() > keep) void'(frame_bytes.pop_back());
    endtask

    task automatic run_frame(input int unsigned plen, input bit bad_head, input bit bad_sum,
                             input bit bad_id, input bit bad_item, input int unsigned tail,
                             input int keep, input int fill);
        compose_frame(plen, bad_head, bad_sum, bad_id, bad_item, tail, keep, fill);
        send_frame();
    endtask

    task automatic random_frame();
        int unsigned pick;
        int unsigned plen;
        logic [3:0]  faults;
        pick = $urandom_range(0, 99);
        plen = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 48) : $urandom_range(0, 6);
        if (pick < 55) begin
            compose_frame(plen, 0, 0, 0, 0,
                          ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : 0, -1, -1);
        end else if (pick < 75) begin
            faults = 4'($urandom_range(1, 15));
            compose_frame(plen, faults[0], faults[1], faults[2], faults[3], 0, -1, -1);
        end else if (pick < 88) begin
            if ($urandom_range(0, 1) == 0) plen = $urandom_range(0, 65535);
            faults = 4'($urandom_range(0, 15));
            compose_frame(plen, faults[0], faults[1], faults[2], faults[3], 0,
                          $urandom_range(1, 20 + ((plen < 30) ? plen : 30)), -1);
        end else begin
            frame_bytes.delete();
            repeat ($urandom_range(1, 30)) frame_bytes.push_back(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 1) == 0) frame_bytes[0] = HEAD_HI;
        end
        random_sent += frame_bytes.size();
        send_frame();
    endtask

    initial begin : stimulus
        logic [CFG_DATA_W-1:0] phase_id[4];
        logic [7:0]            phase_item[4];
        frame_pred = new();
        byte_ch.valid <= 1'b0;
        byte_ch.data_byte <= 8'h00;
        byte_ch.last <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= CFG_DEVICE_ID;
        i_cfg_data <= '0;
        i_rst_n <= 1'b0;
        gaps_on = 1'b1;
        hold_left = 0;
        random_sent = 0;
        cur_id = '0;
        cur_item = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // one frame per verdict, then fault priority and truncation points
        write_settings(64'h0123_4567_89AB_CDEF, 8'h5A);
        run_frame(0, 0, 0, 0, 0, 0, -1, -1);
        run_frame(4, 1, 0, 0, 0, 0, -1, -1);
        run_frame(4, 0, 1, 0, 0, 0, -1, -1);
        run_frame(4, 0, 0, 1, 0, 0, -1, -1);
        run_frame(4, 0, 0, 0, 1, 0, -1, -1);
        run_frame(2, 1, 1, 1, 1, 0, -1, -1);
        run_frame(2, 0, 1, 1, 1, 0, -1, -1);
        run_frame(2, 0, 0, 1, 1, 0, -1, -1);
        run_frame(5, 0, 0, 0, 0, 3, -1, -1);
        run_frame(0, 0, 0, 0, 0, 0, 1, -1);
        run_frame(0, 0, 0, 0, 0, 0, 20, -1);
        run_frame(6, 0, 0, 0, 0, 0, 22, -1);
        run_frame(6, 0, 0, 0, 0, 0, 26, -1);
        run_frame(16'hFFFF, 0, 0, 0, 0, 0, 40, -1);
        settle();
        write_settings('1, 8'hFF);
        run_frame(8, 0, 0, 0, 0, 0, -1, 255);
        run_frame(8, 0, 0, 0, 0, 0, -1, 0);
        settle();
        write_settings('0, 8'h00);
        run_frame(3, 0, 0, 0, 0, 0, -1, 0);
        run_frame(3, 0, 0, 0, 0, 0, -1, 255);
        settle();

        phase_id[0] = {$urandom, $urandom};
        phase_id[1] = '0;
        phase_id[2] = '1;
        phase_id[3] = {$urandom, $urandom};
        phase_item[0] = 8'($urandom_range(0, 255));
        phase_item[1] = 8'hFF;
        phase_item[2] = 8'h00;
        phase_item[3] = 8'($urandom_range(0, 255));
        for (int ph = 0; ph < 4; ph++) begin
            write_settings(phase_id[ph], phase_item[ph]);
            gaps_on = (ph != 1);
            if (ph == 2) begin
                // result side holds off while payload keeps coming, then drain fully
                hold_left = HOLD_CYCLES;
                run_frame(40, 0, 0, 0, 0, 0, -1, -1);
                run_frame(40, 0, 0, 0, 0, 0, -1, -1);
                settle();
            end
            while (random_sent < (ph + 1) * RANDOM_BYTES / 4) begin
                random_frame();
                if ($urandom_range(0, 39) == 0) settle();
            end
            settle();
        end

        $display("frames checked: %0d bytes in, %0d payload bytes forwarded",
                 frame_pred.byte_count, frame_pred.payload_count);
        $display("verdicts ok/short/header/sum/device/item: %0d/%0d/%0d/%0d/%0d/%0d",
                 frame_pred.verdict_count[ST_OK], frame_pred.verdict_count[ST_SHORT],
                 frame_pred.verdict_count[ST_BAD_HEADER], frame_pred.verdict_count[ST_BAD_SUM],
                 frame_pred.verdict_count[ST_OTHER_DEV], frame_pred.verdict_count[ST_OTHER_ITEM]);
        if (frame_pred.mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d mismatching results", frame_pred.mismatch_count);
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule : framed_packet_receive_checker_tb

[files.f]
src/fprc_pkg.sv
src/fprc_byte_if.sv
src/fprc_result_if.sv
src/fprc_cfg_regs.sv
src/fprc_frame_core.sv
src/framed_packet_receive_checker.sv
sim/fprc_frame_model_pkg.sv
sim/framed_packet_receive_checker_tb.sv
